// ===== hdl/pru_pkg.sv =====
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types, codes and constants of the PNG row reconstruction block.
// ----------------------------------------------------------------------------
package pru_pkg;

    // Default sizing
    localparam int ROW_MAX_DEF         = 8192;
    localparam int PIXEL_BYTES_MAX_DEF = 3;

    // Field widths
    localparam int BYTE_W      = 8;
    localparam int ROW_BYTES_W = 14;
    localparam int BPP_W       = 2;
    localparam int KIND_W      = 3;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // Largest legal filter type code
    localparam logic [BYTE_W-1:0] FILTER_MAX = 8'd4;

    // Register reset values
    localparam logic                   PNG_ENABLE_RST = 1'b1;
    localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST  = 14'd1;
    localparam logic [BPP_W-1:0]       BPP_RST        = 2'd1;

    // Register index (byte address / 4)
    typedef enum logic [1:0] {
        REG_PNG_ENABLE = 2'd0,
        REG_ROW_BYTES  = 2'd1,
        REG_BPP        = 2'd2
    } reg_idx_t;

    // PNG filter types
    typedef enum logic [KIND_W-1:0] {
        KIND_NONE  = 3'd0,
        KIND_SUB   = 3'd1,
        KIND_UP    = 3'd2,
        KIND_AVG   = 3'd3,
        KIND_PAETH = 3'd4
    } kind_t;

    // Operation carried from the control stage to the reconstruction stage
    typedef enum logic [1:0] {
        OP_PASS   = 2'd0,
        OP_PNG    = 2'd1,
        OP_FILTER = 2'd2,
        OP_ERROR  = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
        kind_t             kind;
        logic              last;
        logic              has_left;
    } item_t;

    typedef struct packed {
        logic                   png_enable;
        logic [ROW_BYTES_W-1:0] row_bytes;
        logic [BPP_W-1:0]       bytes_per_pixel;
    } cfg_t;

    // Write event on the mode register
    typedef struct packed {
        logic wr;
        logic value;
    } mode_wr_t;

endpackage

// ===== hdl/pru_in_if.sv =====
// ----------------------------------------------------------------------------
// pru_in_if
// Input byte stream channel: valid/ready handshake with one data byte.
// ----------------------------------------------------------------------------
interface pru_in_if;
    import pru_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

// ===== hdl/pru_out_if.sv =====
// ----------------------------------------------------------------------------
// pru_out_if
// Output channel: reconstructed byte, end-of-row flag and filter error flag.
// ----------------------------------------------------------------------------
interface pru_out_if;
    import pru_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel_byte;
    logic              row_last;
    logic              bad_filter;

    modport source (output valid, output pixel_byte, output row_last, output bad_filter,
                    input ready);
    modport sink (input valid, input pixel_byte, input row_last, input bad_filter,
                  output ready);
endinterface

// ===== hdl/png_row_unfilter.sv =====
// ----------------------------------------------------------------------------
// png_row_unfilter
// PNG row filter reconstruction (none, sub, up, average, Paeth).
// ----------------------------------------------------------------------------
// Each accepted byte passes a control stage that issues the read of the
// previous-row memory, then a reconstruction stage that uses the registered
// read data, writes the rebuilt byte back and loads the output register.
// Sustained rate is one byte per cycle while the output is not stalled, set
// by the single write and read port of the previous-row memory; a
// write-to-read forward covers back-to-back access to the same column.
// Filter-type bytes give no transaction. A filter type above 4 gives one
// error transaction (bad_filter set, other fields zero), after which input
// is accepted and dropped until reset. The previous row reads as zero after
// reset through a high-water mark on written columns, so there is no
// clearing pass. Registers: png_enable at 0x0, row_bytes at 0x4,
// bytes_per_pixel at 0x8; write them only while the block is idle.
// ----------------------------------------------------------------------------
module png_row_unfilter #(
    parameter int ROW_MAX         = pru_pkg::ROW_MAX_DEF,
    parameter int PIXEL_BYTES_MAX = pru_pkg::PIXEL_BYTES_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pru_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pru_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pru_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    pru_in_if.sink                         raw,
    pru_out_if.source                      pix
);
    import pru_pkg::*;

    localparam int CW  = $clog2(ROW_MAX);
    localparam int RIW = (PIXEL_BYTES_MAX > 1) ? $clog2(PIXEL_BYTES_MAX) : 1;

    cfg_t           cfg;
    mode_wr_t       mode_wr;
    logic           s1_ready;
    logic           s0_valid;
    item_t          s0_item;
    logic [CW-1:0]  s0_col;
    logic [RIW-1:0] s0_ri;
    logic [RIW-1:0] s0_lidx;

    pru_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .mode_wr (mode_wr)
    );

    pru_ctrl #(
        .ROW_MAX         (ROW_MAX),
        .PIXEL_BYTES_MAX (PIXEL_BYTES_MAX)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .raw      (raw),
        .cfg      (cfg),
        .mode_wr  (mode_wr),
        .s1_ready (s1_ready),
        .s0_valid (s0_valid),
        .s0_item  (s0_item),
        .s0_col   (s0_col),
        .s0_ri    (s0_ri),
        .s0_lidx  (s0_lidx)
    );

    pru_recon #(
        .ROW_MAX         (ROW_MAX),
        .PIXEL_BYTES_MAX (PIXEL_BYTES_MAX)
    ) u_recon (
        .clk      (clk),
        .rst_n    (rst_n),
        .s0_valid (s0_valid),
        .s0_item  (s0_item),
        .s0_col   (s0_col),
        .s0_ri    (s0_ri),
        .s0_lidx  (s0_lidx),
        .s1_ready (s1_ready),
        .pix      (pix)
    );
endmodule

// ===== hdl/pru_ram.sv =====
// ----------------------------------------------------------------------------
// pru_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module pru_ram #(
    parameter int WIDTH = pru_pkg::BYTE_W,
    parameter int DEPTH = pru_pkg::ROW_MAX_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hdl/pru_regs.sv =====
// ----------------------------------------------------------------------------
// pru_regs
// APB configuration registers: mode, row length and pixel size.
// ----------------------------------------------------------------------------
module pru_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pru_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pru_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pru_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output pru_pkg::cfg_t                    cfg,
    output pru_pkg::mode_wr_t                mode_wr
);
    import pru_pkg::*;

    logic                   png_enable_reg;
    logic [ROW_BYTES_W-1:0] row_bytes_reg;
    logic [BPP_W-1:0]       bpp_reg;
    logic                   wr_en;
    reg_idx_t               idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            png_enable_reg <= PNG_ENABLE_RST;
            row_bytes_reg  <= ROW_BYTES_RST;
            bpp_reg        <= BPP_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_PNG_ENABLE: png_enable_reg <= pwdata[0];
                REG_ROW_BYTES:  row_bytes_reg  <= pwdata[ROW_BYTES_W-1:0];
                REG_BPP:        bpp_reg        <= pwdata[BPP_W-1:0];
                default:        ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_PNG_ENABLE: prdata = {{(APB_DATA_W-1){1'b0}}, png_enable_reg};
            REG_ROW_BYTES:  prdata = {{(APB_DATA_W-ROW_BYTES_W){1'b0}}, row_bytes_reg};
            REG_BPP:        prdata = {{(APB_DATA_W-BPP_W){1'b0}}, bpp_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.png_enable      = png_enable_reg;
    assign cfg.row_bytes       = row_bytes_reg;
    assign cfg.bytes_per_pixel = bpp_reg;

    // Mode write event for the row-start bookkeeping
    assign mode_wr.wr    = wr_en && (idx == REG_PNG_ENABLE);
    assign mode_wr.value = pwdata[0];

    // Assertions
    a_ready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready) else $error("pready must stay high");
    a_mode_written: assert property (@(posedge clk) disable iff (!rst_n)
        mode_wr.wr |=> (cfg.png_enable == $past(pwdata[0])))
        else $error("mode register did not take the written value");
    a_bpp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && idx == REG_BPP) |=> $stable(cfg.bytes_per_pixel))
        else $error("pixel size changed without a write");
endmodule

// ===== hdl/pru_ctrl.sv =====
// ----------------------------------------------------------------------------
// pru_ctrl
// Row control stage: tracks filter bytes, column position and the error
// latch, and issues the previous-row read for each data byte.
// ----------------------------------------------------------------------------
module pru_ctrl #(
    parameter int ROW_MAX         = pru_pkg::ROW_MAX_DEF,
    parameter int PIXEL_BYTES_MAX = pru_pkg::PIXEL_BYTES_MAX_DEF,
    localparam int CW  = $clog2(ROW_MAX),
    localparam int RIW = (PIXEL_BYTES_MAX > 1) ? $clog2(PIXEL_BYTES_MAX) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    pru_in_if.sink            raw,
    input  pru_pkg::cfg_t     cfg,
    input  pru_pkg::mode_wr_t mode_wr,
    input  logic              s1_ready,
    output logic              s0_valid,
    output pru_pkg::item_t    s0_item,
    output logic [CW-1:0]     s0_col,
    output logic [RIW-1:0]    s0_ri,
    output logic [RIW-1:0]    s0_lidx
);
    import pru_pkg::*;

    logic [CW-1:0]  col_reg, col_next;
    logic           expect_reg, expect_next;
    kind_t          kind_reg, kind_next;
    logic           err_reg, err_next;
    logic [RIW-1:0] mod_reg [PIXEL_BYTES_MAX];
    logic [RIW-1:0] mod_next [PIXEL_BYTES_MAX];
    logic           fire;
    logic           row_end;
    int unsigned    len_int;
    int unsigned    bpp_int;

    assign raw.ready = s1_ready;
    assign fire      = raw.valid && s1_ready;

    // Effective row length and pixel size
    always_comb
    begin
        len_int = int'(cfg.row_bytes);
        if (len_int == 0)
        begin
            len_int = 1;
        end
        if (len_int > ROW_MAX)
        begin
            len_int = ROW_MAX;
        end
        bpp_int = int'(cfg.bytes_per_pixel);
        if (bpp_int == 0)
        begin
            bpp_int = 1;
        end
        if (bpp_int > PIXEL_BYTES_MAX)
        begin
            bpp_int = PIXEL_BYTES_MAX;
        end
    end

    assign row_end = (int'(col_reg) + 1) >= len_int;
    assign s0_col  = col_reg;
    assign s0_lidx = RIW'(bpp_int - 1);
    assign s0_ri   = mod_reg[s0_lidx];

    // Next state and stage-0 item
    always_comb
    begin
        col_next    = col_reg;
        expect_next = expect_reg;
        kind_next   = kind_reg;
        err_next    = err_reg;
        mod_next    = mod_reg;
        s0_valid    = 1'b0;

        s0_item.op       = OP_PASS;
        s0_item.data     = raw.data_byte;
        s0_item.kind     = kind_reg;
        s0_item.last     = 1'b0;
        s0_item.has_left = int'(col_reg) >= bpp_int;

        if (fire && !err_reg)
        begin
            s0_valid = 1'b1;
            if (cfg.png_enable && expect_reg)
            begin
                if (raw.data_byte > FILTER_MAX)
                begin
                    err_next     = 1'b1;
                    s0_item.op   = OP_ERROR;
                    s0_item.data = '0;
                end
                else
                begin
                    kind_next   = kind_t'(raw.data_byte[KIND_W-1:0]);
                    expect_next = 1'b0;
                    s0_item.op  = OP_FILTER;
                end
            end
            else
            begin
                s0_item.op   = cfg.png_enable ? OP_PNG : OP_PASS;
                s0_item.last = row_end;
                if (row_end)
                begin
                    col_next    = '0;
                    expect_next = cfg.png_enable;
                    for (int m = 0; m < PIXEL_BYTES_MAX; m++)
                    begin
                        mod_next[m] = '0;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                    // column modulo each possible pixel size
                    for (int m = 0; m < PIXEL_BYTES_MAX; m++)
                    begin
                        mod_next[m] = (mod_reg[m] == RIW'(m)) ? '0 : mod_reg[m] + 1'b1;
                    end
                end
            end
        end
        else if (mode_wr.wr && col_reg == '0)
        begin
            expect_next = mode_wr.value;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            expect_reg <= PNG_ENABLE_RST;
            kind_reg   <= KIND_NONE;
            err_reg    <= 1'b0;
            for (int m = 0; m < PIXEL_BYTES_MAX; m++)
            begin
                mod_reg[m] <= '0;
            end
        end
        else
        begin
            col_reg    <= col_next;
            expect_reg <= expect_next;
            kind_reg   <= kind_next;
            err_reg    <= err_next;
            mod_reg    <= mod_next;
        end
    end

    // Assertions
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg) else $error("error latch cleared without reset");
    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> !s0_valid) else $error("item issued after filter error");
    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid && s0_item.last |=> col_reg == '0)
        else $error("column did not wrap at end of row");
endmodule

// ===== hdl/pru_recon.sv =====
// ----------------------------------------------------------------------------
// pru_recon
// Reconstruction stage: previous-row memory with write-back and forwarding,
// left/up-left history, predictor and the output register.
// ----------------------------------------------------------------------------
module pru_recon #(
    parameter int ROW_MAX         = pru_pkg::ROW_MAX_DEF,
    parameter int PIXEL_BYTES_MAX = pru_pkg::PIXEL_BYTES_MAX_DEF,
    localparam int CW  = $clog2(ROW_MAX),
    localparam int RIW = (PIXEL_BYTES_MAX > 1) ? $clog2(PIXEL_BYTES_MAX) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s0_valid,
    input  pru_pkg::item_t s0_item,
    input  logic [CW-1:0]  s0_col,
    input  logic [RIW-1:0] s0_ri,
    input  logic [RIW-1:0] s0_lidx,
    output logic           s1_ready,
    pru_out_if.source      pix
);
    import pru_pkg::*;

    // Stage 1 registers
    logic              s1_valid_reg;
    item_t             s1_item_reg;
    logic [CW-1:0]     s1_col_reg;
    logic [RIW-1:0]    s1_ri_reg;
    logic [RIW-1:0]    s1_lidx_reg;
    logic              fwd_hit_reg;
    logic [BYTE_W-1:0] fwd_data_reg;
    logic              rd_zero_reg;
    logic [CW:0]       hiwater_reg;
    logic [BYTE_W-1:0] ring_reg [PIXEL_BYTES_MAX];
    logic [BYTE_W-1:0] hist_reg [PIXEL_BYTES_MAX];

    // Output register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_pixel_reg;
    logic              out_last_reg;
    logic              out_bad_reg;

    logic              out_free;
    logic              has_out;
    logic              s1_go;
    logic              mem_we;
    logic [BYTE_W-1:0] rdata;
    logic [BYTE_W-1:0] up;
    logic [BYTE_W-1:0] left;
    logic [BYTE_W-1:0] ul;
    logic [BYTE_W-1:0] pred;
    logic [BYTE_W-1:0] result;
    logic [BYTE_W:0]   avg_sum;
    logic [BYTE_W+1:0] pa_sum;
    logic [BYTE_W+1:0] pa_c2;
    logic [BYTE_W-1:0] da;
    logic [BYTE_W-1:0] db;
    logic [BYTE_W+1:0] dc;
    logic [BYTE_W-1:0] paeth;

    // Flow control
    assign out_free = !out_valid_reg || pix.ready;
    assign has_out  = s1_item_reg.op != OP_FILTER;
    assign s1_go    = s1_valid_reg && (!has_out || out_free);
    assign s1_ready = !s1_valid_reg || s1_go;
    assign mem_we   = s1_go && (s1_item_reg.op == OP_PNG || s1_item_reg.op == OP_PASS);

    pru_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (ROW_MAX)
    ) u_prev_row (
        .clk   (clk),
        .we    (mem_we),
        .waddr (s1_col_reg),
        .wdata (result),
        .re    (s0_valid),
        .raddr (s0_col),
        .rdata (rdata)
    );

    // Neighbor bytes
    assign up   = fwd_hit_reg ? fwd_data_reg : (rd_zero_reg ? '0 : rdata);
    assign left = s1_item_reg.has_left ? hist_reg[s1_lidx_reg] : '0;
    assign ul   = s1_item_reg.has_left ? ring_reg[s1_ri_reg] : '0;

    // Paeth selection: distances |b-c|, |a-c|, |a+b-2c|
    always_comb
    begin
        pa_sum = {2'b00, left} + {2'b00, up};
        pa_c2  = {1'b0, ul, 1'b0};
        da     = (up > ul) ? up - ul : ul - up;
        db     = (left > ul) ? left - ul : ul - left;
        dc     = (pa_sum > pa_c2) ? pa_sum - pa_c2 : pa_c2 - pa_sum;
        if (da <= db && {2'b00, da} <= dc)
        begin
            paeth = left;
        end
        else if ({2'b00, db} <= dc)
        begin
            paeth = up;
        end
        else
        begin
            paeth = ul;
        end
    end

    // Predictor and result
    always_comb
    begin
        avg_sum = {1'b0, left} + {1'b0, up};
        case (s1_item_reg.kind)
            KIND_SUB:   pred = left;
            KIND_UP:    pred = up;
            KIND_AVG:   pred = avg_sum[BYTE_W:1];
            KIND_PAETH: pred = paeth;
            default:    pred = '0;
        endcase
        case (s1_item_reg.op)
            OP_PNG:  result = s1_item_reg.data + pred;
            OP_PASS: result = s1_item_reg.data;
            default: result = '0;
        endcase
    end

    // Stage 1 control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            hiwater_reg  <= '0;
            for (int i = 0; i < PIXEL_BYTES_MAX; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= s0_valid;
            end
            // Written entries always form a prefix of the row memory
            if (mem_we && {1'b0, s1_col_reg} == hiwater_reg)
            begin
                hiwater_reg <= hiwater_reg + 1'b1;
            end
            if (s1_go && s1_item_reg.op == OP_FILTER)
            begin
                for (int i = 0; i < PIXEL_BYTES_MAX; i++)
                begin
                    ring_reg[i] <= '0;
                end
            end
            else if (s1_go && s1_item_reg.op == OP_PNG)
            begin
                ring_reg[s1_ri_reg] <= up;
            end
        end
    end

    // Stage 1 payload, forwarding and left history
    always_ff @(posedge clk)
    begin
        if (s0_valid)
        begin
            s1_item_reg  <= s0_item;
            s1_col_reg   <= s0_col;
            s1_ri_reg    <= s0_ri;
            s1_lidx_reg  <= s0_lidx;
            fwd_hit_reg  <= mem_we && (s1_col_reg == s0_col);
            fwd_data_reg <= result;
            rd_zero_reg  <= !({1'b0, s0_col} < hiwater_reg);
        end
        if (mem_we)
        begin
            hist_reg[0] <= result;
            for (int i = 1; i < PIXEL_BYTES_MAX; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && has_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && has_out)
        begin
            out_pixel_reg <= result;
            out_last_reg  <= (s1_item_reg.op != OP_ERROR) && s1_item_reg.last;
            out_bad_reg   <= s1_item_reg.op == OP_ERROR;
        end
    end

    assign pix.valid      = out_valid_reg;
    assign pix.pixel_byte = out_pixel_reg;
    assign pix.row_last   = out_last_reg;
    assign pix.bad_filter = out_bad_reg;

    // Assertions
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> {1'b0, s1_col_reg} <= hiwater_reg)
        else $error("write beyond written prefix of row memory");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_bad_reg |-> (out_pixel_reg == '0) && !out_last_reg)
        else $error("error transaction carries data");
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_col_reg))
        else $error("stalled stage 1 item lost");
endmodule

// ===== sim/png_row_unfilter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_row_unfilter_test
// Self-checking bench for the PNG row reconstruction block.
// ----------------------------------------------------------------------------
// A byte stream goes in through the raw channel with random gaps, and results
// are taken from the pix channel under random back-pressure. A predictor in
// the bench rebuilds every row with its own previous-row copy and config
// shadow, and a checker compares each output transaction with the oldest
// prediction. Directed rows cover each filter kind, pixel sizes, mode
// switches at a row start and mid-row, and rows cut short. The random part
// sends mostly well-formed rows under changing config, a long row under the
// oversized and the full row length follows, and the run closes with an
// illegal filter type.
// ----------------------------------------------------------------------------
module png_row_unfilter_test;
    import pru_pkg::*;

    localparam int HALF_PERIOD    = 1;
    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ROW_LIMIT      = ROW_MAX_DEF;
    localparam int PIXEL_LIMIT    = PIXEL_BYTES_MAX_DEF;
    localparam int RANDOM_ITEMS   = 400;
    localparam int LONG_ROW_PART  = 40;

    // Index with no register behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_TOP = '1;
    localparam logic [BPP_W-1:0] BPP_TOP = '1;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
        logic              bad;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    pru_in_if raw_if ();
    pru_out_if pix_if ();

    png_row_unfilter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .raw     (raw_if),
        .pix     (pix_if)
    );

    // Predictor state: config shadow and row reconstruction state
    logic                   png_en    = PNG_ENABLE_RST;
    logic [ROW_BYTES_W-1:0] rows_cfg  = ROW_BYTES_RST;
    logic [BPP_W-1:0]       bpp_cfg   = BPP_RST;
    logic [BYTE_W-1:0]      prev_row [ROW_LIMIT];
    logic [BYTE_W-1:0]      ul_ring [PIXEL_LIMIT];
    kind_t                  cur_kind  = KIND_NONE;
    int unsigned            col_pos   = 0;
    logic                   want_filter = PNG_ENABLE_RST;
    logic                   err_seen  = 1'b0;

    pixel_t pending_pixels [$];
    int     fail_count   = 0;
    bit     steady_mode  = 1'b0;
    int     quiet_cycles = 0;

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int unsigned row_len();
        if (rows_cfg == 0)
            return 1;
        if (rows_cfg > ROW_LIMIT)
            return ROW_LIMIT;
        return rows_cfg;
    endfunction

    function automatic int unsigned pixel_step();
        if (bpp_cfg == 0)
            return 1;
        if (bpp_cfg > PIXEL_LIMIT)
            return PIXEL_LIMIT;
        return bpp_cfg;
    endfunction

    // Paeth: pick the neighbor closest to left + up - upleft, ties to left then up
    function automatic logic [BYTE_W-1:0] paeth_choose(input logic [BYTE_W-1:0] a, b, c);
        int da;
        int db;
        int dc;
        da = int'(b) - int'(c);
        db = int'(a) - int'(c);
        dc = int'(a) + int'(b) - 2 * int'(c);
        if (da < 0)
            da = -da;
        if (db < 0)
            db = -db;
        if (dc < 0)
            dc = -dc;
        if (da <= db && da <= dc)
            return a;
        if (db <= dc)
            return b;
        return c;
    endfunction

    // Rebuild one accepted byte and queue the transaction it should produce
    task automatic predict_pixel(input logic [BYTE_W-1:0] b);
        int unsigned bpp;
        int unsigned ring_slot;
        logic [BYTE_W-1:0] up;
        logic [BYTE_W-1:0] left;
        logic [BYTE_W-1:0] upleft;
        logic [BYTE_W-1:0] guess;
        logic [BYTE_W-1:0] rebuilt;
        logic row_end;
        if (!err_seen && png_en && want_filter)
        begin
            if (b > FILTER_MAX)
            begin
                err_seen = 1'b1;
                pending_pixels.push_back('{value: '0, last: 1'b0, bad: 1'b1});
            end
            else
            begin
                cur_kind = kind_t'(b[KIND_W-1:0]);
                foreach (ul_ring[i])
                    ul_ring[i] = '0;
                want_filter = 1'b0;
            end
        end
        else if (!err_seen)
        begin
            rebuilt = b;
            if (png_en)
            begin
                bpp = pixel_step();
                ring_slot = col_pos % bpp;
                up = prev_row[col_pos];
                left = (col_pos >= bpp) ? prev_row[col_pos - bpp] : '0;
                upleft = (col_pos >= bpp) ? ul_ring[ring_slot] : '0;
                ul_ring[ring_slot] = up;
                case (cur_kind)
                    KIND_SUB:   guess = left;
                    KIND_UP:    guess = up;
                    KIND_AVG:   guess = BYTE_W'((int'(left) + int'(up)) / 2);
                    KIND_PAETH: guess = paeth_choose(left, up, upleft);
                    default:    guess = '0;
                endcase
                rebuilt = b + guess;
            end
            prev_row[col_pos] = rebuilt;
            row_end = (col_pos + 1 >= row_len());
            if (row_end)
            begin
                col_pos = 0;
                want_filter = png_en;
            end
            else
                col_pos++;
            pending_pixels.push_back('{value: rebuilt, last: row_end, bad: 1'b0});
        end
    endtask

    // Config shadow update at the write edge
    task automatic update_config(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        case (idx)
            REG_PNG_ENABLE:
            begin
                png_en = value[0];
                if (col_pos == 0)
                    want_filter = value[0];
            end
            REG_ROW_BYTES: rows_cfg = value[ROW_BYTES_W-1:0];
            REG_BPP:       bpp_cfg = value[BPP_W-1:0];
            default:       ;
        endcase
    endtask

    function automatic logic [APB_DATA_W-1:0] cfg_readback(input logic [1:0] idx);
        case (idx)
            REG_PNG_ENABLE: return APB_DATA_W'(png_en);
            REG_ROW_BYTES:  return APB_DATA_W'(rows_cfg);
            default:        return APB_DATA_W'(bpp_cfg);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        fail_count++;
    endtask

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int roll;
        if (steady_mode)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [BYTE_W-1:0] random_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Filter type where one is due, data otherwise
    function automatic logic [BYTE_W-1:0] next_stream_byte();
        if (png_en && want_filter)
            return BYTE_W'($urandom_range(int'(KIND_NONE), int'(KIND_PAETH)));
        return random_byte();
    endfunction

    // One input transaction; valid stays high if no gap follows
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        raw_if.valid <= 1'b1;
        raw_if.data_byte <= b;
        @(posedge clk);
        while (!raw_if.ready)
            @(posedge clk);
        predict_pixel(b);
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            raw_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stop sending and wait until every predicted transaction is out
    task automatic drain_pipeline();
        raw_if.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic finish_row();
        while (col_pos != 0)
            send_byte(random_byte());
    endtask

    // APB write: setup, access, then back to idle on the bus
    task automatic apb_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        update_config(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apb_read(input logic [1:0] idx, output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_registers();
        logic [APB_DATA_W-1:0] got;
        for (int i = REG_PNG_ENABLE; i <= REG_BPP; i++)
        begin
            apb_read(2'(i), got);
            if (got !== cfg_readback(2'(i)))
                report_mismatch($sformatf("register %0d reads %08h, expected %08h",
                                          i, got, cfg_readback(2'(i))));
        end
    endtask

    // Random register write with junk in the unused upper bits
    task automatic random_reg_write();
        logic [APB_DATA_W-1:0] noise;
        int roll;
        int rows;
        noise = $urandom();
        roll = $urandom_range(0, 19);
        rows = (roll == 0) ? 0 : (roll == 1) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        case ($urandom_range(0, 2))
            0: apb_write(REG_PNG_ENABLE, {noise[31:1], 1'($urandom_range(0, 4) != 0)});
            1: apb_write(REG_ROW_BYTES, {noise[31:ROW_BYTES_W], ROW_BYTES_W'(rows)});
            default: apb_write(REG_BPP, {noise[31:BPP_W], BPP_W'($urandom_range(0, 3))});
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        check_registers();
    endtask

    // Every filter kind on two-byte rows with byte extremes
    task automatic test_filter_kinds();
        drain_pipeline();
        apb_write(REG_ROW_BYTES, 2);
        apb_write(REG_BPP, 1);
        for (int k = KIND_NONE; k <= KIND_PAETH; k++)
        begin
            send_byte(BYTE_W'(k));
            send_byte(8'hFF);
            send_byte(8'h00);
        end
    endtask

    // Widest pixel, then zero pixel size and zero row length (both count as one)
    task automatic test_pixel_sizes();
        drain_pipeline();
        apb_write(REG_ROW_BYTES, 4);
        apb_write(REG_BPP, APB_DATA_W'(BPP_TOP));
        send_byte(BYTE_W'(KIND_SUB));
        repeat (4) send_byte(random_byte());
        drain_pipeline();
        apb_write(REG_BPP, 0);
        apb_write(REG_ROW_BYTES, 0);
        send_byte(BYTE_W'(KIND_AVG));
        send_byte(random_byte());
    endtask

    task automatic test_mode_changes();
        drain_pipeline();
        apb_write(REG_ROW_BYTES, 3);
        // off at a row start: bytes pass through
        apb_write(REG_PNG_ENABLE, 0);
        send_byte(8'hA5);
        send_byte(8'h5A);
        // on mid-row: rest of the row uses the last stored filter kind
        drain_pipeline();
        apb_write(REG_PNG_ENABLE, 1);
        send_byte(8'h11);
        send_byte(BYTE_W'(KIND_SUB));
        // rewritten after the filter byte, still at column zero: new filter byte due
        drain_pipeline();
        apb_write(REG_PNG_ENABLE, 1);
        send_byte(BYTE_W'(KIND_PAETH));
        send_byte(8'h01);
        send_byte(8'hFE);
        // off mid-row: passes at once, no filter byte after the row
        drain_pipeline();
        apb_write(REG_PNG_ENABLE, 0);
        send_byte(8'h33);
        send_byte(8'h44);
        // row cut short below the current column: next byte ends it
        drain_pipeline();
        apb_write(REG_ROW_BYTES, 8);
        repeat (3) send_byte(random_byte());
        drain_pipeline();
        apb_write(REG_ROW_BYTES, 2);
        send_byte(8'h77);
        drain_pipeline();
        apb_write(REG_UNUSED, '1);
        apb_write(REG_PNG_ENABLE, 1);
        check_registers();
    endtask

    // Phases of well-formed rows under random config, written when idle
    task automatic test_random_stream(input int n_items);
        int sent;
        int phase_len;
        sent = 0;
        while (sent < n_items)
        begin
            drain_pipeline();
            repeat ($urandom_range(0, 3)) random_reg_write();
            steady_mode = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(4, 60);
            repeat (phase_len) send_byte(next_stream_byte());
            sent += phase_len;
        end
        steady_mode = 1'b0;
    endtask

    // One row past the usual sizes: oversized length (clamped), then the full
    // length, then cut short so the next byte ends it
    task automatic test_longest_row();
        finish_row();
        drain_pipeline();
        apb_write(REG_PNG_ENABLE, 1);
        apb_write(REG_BPP, APB_DATA_W'(BPP_TOP));
        apb_write(REG_ROW_BYTES, APB_DATA_W'(ROW_BYTES_TOP));
        send_byte(BYTE_W'(KIND_PAETH));
        repeat (LONG_ROW_PART) send_byte(random_byte());
        drain_pipeline();
        apb_write(REG_ROW_BYTES, ROW_LIMIT);
        repeat (LONG_ROW_PART) send_byte(random_byte());
        drain_pipeline();
        apb_write(REG_ROW_BYTES, 3);
        send_byte(random_byte());
    endtask

    // Illegal filter type latches the error; later input is dropped
    task automatic test_bad_filter();
        finish_row();
        drain_pipeline();
        apb_write(REG_PNG_ENABLE, 1);
        send_byte(BYTE_W'($urandom_range(int'(FILTER_MAX) + 1, 255)));
        repeat (20) send_byte(random_byte());
        drain_pipeline();
        apb_write(REG_ROW_BYTES, 5);
        check_registers();
    endtask

    // ------------------------------------------------------------------
    // Output back-pressure
    // ------------------------------------------------------------------
    initial
    begin : output_stalls
        int hold;
        hold = 0;
        pix_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                pix_if.ready <= 1'b0;
                hold--;
            end
            else
            begin
                pix_if.ready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Output checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_output
        pixel_t want;
        if (rst_n && pix_if.valid && pix_if.ready)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch($sformatf("unexpected transaction: pixel %02h last %0b bad %0b",
                                          pix_if.pixel_byte, pix_if.row_last,
                                          pix_if.bad_filter));
            else
            begin
                want = pending_pixels.pop_front();
                if (pix_if.pixel_byte !== want.value)
                    report_mismatch($sformatf("pixel_byte %02h, expected %02h",
                                              pix_if.pixel_byte, want.value));
                if (pix_if.row_last !== want.last)
                    report_mismatch($sformatf("row_last %0b, expected %0b",
                                              pix_if.row_last, want.last));
                if (pix_if.bad_filter !== want.bad)
                    report_mismatch($sformatf("bad_filter %0b, expected %0b",
                                              pix_if.bad_filter, want.bad));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transaction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (raw_if.valid && raw_if.ready) || (pix_if.valid && pix_if.ready)
            || (psel && penable))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        foreach (prev_row[i])
            prev_row[i] = '0;
        foreach (ul_ring[i])
            ul_ring[i] = '0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        raw_if.valid = 1'b0;
        raw_if.data_byte = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_filter_kinds();
        test_pixel_sizes();
        test_mode_changes();
        test_random_stream(RANDOM_ITEMS);
        test_longest_row();
        test_random_stream(RANDOM_ITEMS);
        test_bad_filter();

        drain_pipeline();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
